[sv/slu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slu_pkg;

  typedef enum logic [3:0] {
    PH_START        = 4'd0,
    PH_AFTER_PREFIX = 4'd1,
    PH_AT_SEEN      = 4'd2,
    PH_VERB_BODY    = 4'd3,
    PH_QUOTED       = 4'd4,
    PH_ESC_START    = 4'd5,
    PH_HEX_RUN      = 4'd6,
    PH_DEC_RUN      = 4'd7,
    PH_OCT_RUN      = 4'd8,
    PH_FIXED_HEX    = 4'd9,
    PH_CLOSED       = 4'd10,
    PH_SWALLOW      = 4'd11,
    PH_ERROR        = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_INVALID      = 2'd1,
    ST_HEX_EXPECTED = 2'd2
  } status_t;

  localparam logic [1:0] PFX_NONE = 2'd0;
  localparam logic [1:0] PFX_W    = 2'd1;
  localparam logic [1:0] PFX_U    = 2'd2;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] CH_AT     = CP_W'('h40);
  localparam logic [CP_W-1:0] CH_QUOTE  = CP_W'('h22);
  localparam logic [CP_W-1:0] CH_BSLASH = CP_W'('h5C);
  localparam logic [CP_W-1:0] CH_CR     = CP_W'('h0D);
  localparam logic [CP_W-1:0] CH_LF     = CP_W'('h0A);
  localparam logic [CP_W-1:0] CH_LO_W   = CP_W'('h77);
  localparam logic [CP_W-1:0] CH_LO_U   = CP_W'('h75);
  localparam logic [CP_W-1:0] CH_UP_U   = CP_W'('h55);
  localparam logic [CP_W-1:0] CH_LO_X   = CP_W'('h78);
  localparam logic [CP_W-1:0] CH_UP_X   = CP_W'('h58);
  localparam logic [CP_W-1:0] CH_LO_D   = CP_W'('h64);
  localparam logic [CP_W-1:0] CH_UP_D   = CP_W'('h44);
  localparam logic [CP_W-1:0] CH_LO_A   = CP_W'('h61);
  localparam logic [CP_W-1:0] CH_LO_B   = CP_W'('h62);
  localparam logic [CP_W-1:0] CH_LO_F   = CP_W'('h66);
  localparam logic [CP_W-1:0] CH_LO_N   = CP_W'('h6E);
  localparam logic [CP_W-1:0] CH_LO_R   = CP_W'('h72);
  localparam logic [CP_W-1:0] CH_LO_T   = CP_W'('h74);
  localparam logic [CP_W-1:0] CH_LO_V   = CP_W'('h76);
  localparam logic [CP_W-1:0] CH_0      = CP_W'('h30);
  localparam logic [CP_W-1:0] CH_7      = CP_W'('h37);
  localparam logic [CP_W-1:0] CH_9      = CP_W'('h39);
  localparam logic [CP_W-1:0] CH_UP_A   = CP_W'('h41);
  localparam logic [CP_W-1:0] CH_UP_F   = CP_W'('h46);

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic [1:0]  prefix;
    logic [1:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_val(input logic [CP_W-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = c[3:0];
    if (c >= CH_0 && c <= CH_9) begin
      h.val = c[3:0];
    end else if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

[sv/string_literal_unescaper.sv]
// The results of an accepted item are registered into the result queue and offered in order.
// One item per cycle while each item gives at most one result and out_ready stays high;
//   an item that gives two or three results leaves the queue one result a cycle while out_ready is high.
// A four-entry result queue decouples the sides; input ready whenever three slots are free.
// Reset (synchronous, active high) returns the decoder to the start of a token and empties
//   the queue.
`timescale 1ns / 1ps
`default_nettype none

module string_literal_unescaper (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [20:0] code_point,
  input  wire logic        final_char,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [31:0]      decoded_char,
  output logic [1:0]       prefix_kind,
  output logic [1:0]       status,
  output logic             last_of_run
);

  // decoder state
  slu_pkg::phase_t phase, phase_next;
  logic [31:0]     escape_value, escape_value_next;
  logic [3:0]      digits_left, digits_left_next;
  logic [1:0]      seen_prefix, seen_prefix_next;
  logic [1:0]      error_code, error_code_next;

  // results of the current item, up to three
  slu_pkg::res_t   res [3];
  logic [1:0]      nres;

  // result queue
  slu_pkg::res_t   queue [4];
  logic [1:0]      wr_ptr, rd_ptr;
  logic [2:0]      count;

  logic accept, pop;

  assign accept   = in_valid & in_ready;
  assign pop      = out_valid & out_ready;
  assign in_ready = (count <= 3'd1);
  assign out_valid = (count != 3'd0);

  always_comb begin
    slu_pkg::hex_t h;
    logic          do_quoted;
    logic [31:0]   cp32;
    logic [31:0]   ctl;
    h         = slu_pkg::hex_val(code_point);
    do_quoted = 1'b0;
    cp32      = {11'd0, code_point};
    ctl       = cp32;

    phase_next        = phase;
    escape_value_next = escape_value;
    digits_left_next  = digits_left;
    seen_prefix_next  = seen_prefix;
    error_code_next   = error_code;
    nres              = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end

    unique case (phase)
      slu_pkg::PH_START: begin
        if (code_point == slu_pkg::CH_LO_W) begin
          seen_prefix_next = slu_pkg::PFX_W;
          phase_next       = slu_pkg::PH_AFTER_PREFIX;
        end else if (code_point == slu_pkg::CH_LO_U) begin
          seen_prefix_next = slu_pkg::PFX_U;
          phase_next       = slu_pkg::PH_AFTER_PREFIX;
        end else if (code_point == slu_pkg::CH_AT) begin
          phase_next = slu_pkg::PH_AT_SEEN;
        end else if (code_point == slu_pkg::CH_QUOTE) begin
          phase_next = slu_pkg::PH_QUOTED;
        end else begin
          error_code_next = slu_pkg::ST_INVALID;
          phase_next      = slu_pkg::PH_ERROR;
        end
      end
      slu_pkg::PH_AFTER_PREFIX: begin
        if (code_point == slu_pkg::CH_AT) begin
          phase_next = slu_pkg::PH_AT_SEEN;
        end else if (code_point == slu_pkg::CH_QUOTE) begin
          phase_next = slu_pkg::PH_QUOTED;
        end else begin
          error_code_next = slu_pkg::ST_INVALID;
          phase_next      = slu_pkg::PH_ERROR;
        end
      end
      slu_pkg::PH_AT_SEEN: begin
        // '@' without a quote: rest of the token is dropped
        phase_next = (code_point == slu_pkg::CH_QUOTE) ? slu_pkg::PH_VERB_BODY
                                                       : slu_pkg::PH_SWALLOW;
      end
      slu_pkg::PH_VERB_BODY: begin
        if (code_point == slu_pkg::CH_QUOTE) begin
          phase_next = slu_pkg::PH_CLOSED;
        end else begin
          res[nres].kind  = slu_pkg::KIND_CHAR;
          res[nres].value = cp32;
          nres            = nres + 2'd1;
        end
      end
      slu_pkg::PH_QUOTED: begin
        do_quoted = 1'b1;
      end
      slu_pkg::PH_ESC_START: begin
        escape_value_next = '0;
        if (code_point == slu_pkg::CH_LO_X || code_point == slu_pkg::CH_UP_X) begin
          phase_next = slu_pkg::PH_HEX_RUN;
        end else if (code_point == slu_pkg::CH_LO_D || code_point == slu_pkg::CH_UP_D) begin
          phase_next = slu_pkg::PH_DEC_RUN;
        end else if (code_point >= slu_pkg::CH_0 && code_point <= slu_pkg::CH_7) begin
          escape_value_next = {29'd0, code_point[2:0]};
          phase_next        = slu_pkg::PH_OCT_RUN;
        end else if (code_point == slu_pkg::CH_LO_U) begin
          digits_left_next = 4'd4;
          phase_next       = slu_pkg::PH_FIXED_HEX;
        end else if (code_point == slu_pkg::CH_UP_U) begin
          digits_left_next = 4'd8;
          phase_next       = slu_pkg::PH_FIXED_HEX;
        end else begin
          case (code_point)
            slu_pkg::CH_LO_A: ctl = 32'd7;
            slu_pkg::CH_LO_B: ctl = 32'd8;
            slu_pkg::CH_LO_F: ctl = 32'd12;
            slu_pkg::CH_LO_N: ctl = 32'd10;
            slu_pkg::CH_LO_R: ctl = 32'd13;
            slu_pkg::CH_LO_T: ctl = 32'd9;
            slu_pkg::CH_LO_V: ctl = 32'd11;
            default:          ctl = cp32;
          endcase
          res[nres].kind  = slu_pkg::KIND_CHAR;
          res[nres].value = ctl;
          nres            = nres + 2'd1;
          phase_next      = slu_pkg::PH_QUOTED;
        end
      end
      slu_pkg::PH_HEX_RUN: begin
        if (h.ok) begin
          escape_value_next = {escape_value[27:0], h.val};
        end else begin
          res[nres].kind  = slu_pkg::KIND_CHAR;
          res[nres].value = escape_value;
          nres            = nres + 2'd1;
          do_quoted       = 1'b1;
        end
      end
      slu_pkg::PH_DEC_RUN: begin
        if (code_point >= slu_pkg::CH_0 && code_point <= slu_pkg::CH_9) begin
          escape_value_next = {escape_value[28:0], 3'd0} + {escape_value[30:0], 1'b0}
                            + {28'd0, code_point[3:0]};
        end else begin
          res[nres].kind  = slu_pkg::KIND_CHAR;
          res[nres].value = escape_value;
          nres            = nres + 2'd1;
          do_quoted       = 1'b1;
        end
      end
      slu_pkg::PH_OCT_RUN: begin
        if (code_point >= slu_pkg::CH_0 && code_point <= slu_pkg::CH_7) begin
          escape_value_next = {escape_value[28:0], code_point[2:0]};
        end else begin
          res[nres].kind  = slu_pkg::KIND_CHAR;
          res[nres].value = escape_value;
          nres            = nres + 2'd1;
          do_quoted       = 1'b1;
        end
      end
      slu_pkg::PH_FIXED_HEX: begin
        if (!h.ok) begin
          error_code_next = slu_pkg::ST_HEX_EXPECTED;
          phase_next      = slu_pkg::PH_ERROR;
        end else begin
          escape_value_next = {escape_value[27:0], h.val};
          if (digits_left != 4'd0) begin
            digits_left_next = digits_left - 4'd1;
          end
          if (digits_left <= 4'd1) begin
            res[nres].kind  = slu_pkg::KIND_CHAR;
            res[nres].value = {escape_value[27:0], h.val};
            nres            = nres + 2'd1;
            phase_next      = slu_pkg::PH_QUOTED;
          end
        end
      end
      slu_pkg::PH_CLOSED: begin
        error_code_next = slu_pkg::ST_INVALID;
        phase_next      = slu_pkg::PH_ERROR;
      end
      slu_pkg::PH_SWALLOW: begin
        phase_next = slu_pkg::PH_SWALLOW;
      end
      slu_pkg::PH_ERROR: begin
        phase_next = slu_pkg::PH_ERROR;
      end
      default: begin
        phase_next = slu_pkg::PH_ERROR;
      end
    endcase

    // body character, also the one that ended a numeric run
    if (do_quoted) begin
      if (code_point == slu_pkg::CH_BSLASH) begin
        phase_next = slu_pkg::PH_ESC_START;
      end else if (code_point == slu_pkg::CH_CR || code_point == slu_pkg::CH_LF) begin
        error_code_next = slu_pkg::ST_INVALID;
        phase_next      = slu_pkg::PH_ERROR;
      end else if (code_point == slu_pkg::CH_QUOTE) begin
        phase_next = slu_pkg::PH_CLOSED;
      end else begin
        res[nres].kind  = slu_pkg::KIND_CHAR;
        res[nres].value = cp32;
        nres            = nres + 2'd1;
        phase_next      = slu_pkg::PH_QUOTED;
      end
    end

    // end of token: flush pending escape, then summary
    if (final_char) begin
      case (phase_next) inside
        slu_pkg::PH_START, slu_pkg::PH_AFTER_PREFIX: begin
          error_code_next = slu_pkg::ST_INVALID;
        end
        slu_pkg::PH_ESC_START: begin
          res[nres].kind  = slu_pkg::KIND_CHAR;
          res[nres].value = '0;
          nres            = nres + 2'd1;
        end
        slu_pkg::PH_HEX_RUN, slu_pkg::PH_DEC_RUN, slu_pkg::PH_OCT_RUN: begin
          res[nres].kind  = slu_pkg::KIND_CHAR;
          res[nres].value = escape_value_next;
          nres            = nres + 2'd1;
        end
        slu_pkg::PH_FIXED_HEX: begin
          error_code_next = slu_pkg::ST_HEX_EXPECTED;
        end
        default: begin
          error_code_next = error_code_next;
        end
      endcase
      res[nres].kind   = slu_pkg::KIND_SUMMARY;
      res[nres].value  = '0;
      res[nres].status = error_code_next;
      nres             = nres + 2'd1;

      phase_next        = slu_pkg::PH_START;
      escape_value_next = '0;
      digits_left_next  = '0;
      seen_prefix_next  = slu_pkg::PFX_NONE;
      error_code_next   = slu_pkg::ST_OK;
    end

    // prefix is fixed before any result of the token; mark end of run
    for (int i = 0; i < 3; i++) begin
      res[i].prefix = seen_prefix_next;
      res[i].last   = (2'(i) == nres - 2'd1);
    end
    if (final_char) begin
      for (int i = 0; i < 3; i++) begin
        res[i].prefix = (phase == slu_pkg::PH_START) ?
                        ((code_point == slu_pkg::CH_LO_W) ? slu_pkg::PFX_W :
                         (code_point == slu_pkg::CH_LO_U) ? slu_pkg::PFX_U : slu_pkg::PFX_NONE)
                        : seen_prefix;
      end
    end
  end

  // decoder state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= slu_pkg::PH_START;
      escape_value <= '0;
      digits_left  <= '0;
      seen_prefix  <= slu_pkg::PFX_NONE;
      error_code   <= slu_pkg::ST_OK;
    end else if (accept) begin
      phase        <= phase_next;
      escape_value <= escape_value_next;
      digits_left  <= digits_left_next;
      seen_prefix  <= seen_prefix_next;
      error_code   <= error_code_next;
    end
  end

  // result queue: up to three pushes, one pop per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < nres) begin
          queue[wr_ptr + 2'(i)] <= res[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + nres;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (accept ? {1'b0, nres} : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  assign kind         = queue[rd_ptr].kind;
  assign decoded_char = queue[rd_ptr].value;
  assign prefix_kind  = queue[rd_ptr].prefix;
  assign status       = queue[rd_ptr].status;
  assign last_of_run  = queue[rd_ptr].last;

endmodule

`default_nettype wire

[tb/unescape_check.sv]
`timescale 1ns / 1ps

module unescape_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [20:0] code_point,
  input  logic        final_char,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        kind,
  input  logic [31:0] decoded_char,
  input  logic [1:0]  prefix_kind,
  input  logic [1:0]  status,
  input  logic        last_of_run,
  output int          fail_count,
  output int          pending,
  output int          chars_seen,
  output int          summaries_seen
);

  // control codes for the single-letter escapes
  localparam logic [31:0] CC_BEL = 32'd7;
  localparam logic [31:0] CC_BS  = 32'd8;
  localparam logic [31:0] CC_HT  = 32'd9;
  localparam logic [31:0] CC_LF  = 32'd10;
  localparam logic [31:0] CC_VT  = 32'd11;
  localparam logic [31:0] CC_FF  = 32'd12;
  localparam logic [31:0] CC_CR  = 32'd13;

  // decoder state
  slu_pkg::phase_t  ph;
  logic [31:0]      acc;
  logic [3:0]       need;
  logic [1:0]       pfx;
  slu_pkg::status_t err;

  slu_pkg::res_t due_results[$];
  slu_pkg::res_t want;
  int            made;

  function automatic void clear_decoder();
    ph   = slu_pkg::PH_START;
    acc  = '0;
    need = '0;
    pfx  = slu_pkg::PFX_NONE;
    err  = slu_pkg::ST_OK;
  endfunction

  function automatic void push_res(logic k, logic [31:0] v);
    slu_pkg::res_t r;
    r.kind   = k;
    r.value  = v;
    r.prefix = pfx;
    r.status = (k == slu_pkg::KIND_SUMMARY) ? err : slu_pkg::ST_OK;
    r.last   = 1'b0;
    due_results.push_back(r);
    made++;
  endfunction

  // first error sticks
  function automatic void flag_error(slu_pkg::status_t code);
    if (ph != slu_pkg::PH_ERROR) begin
      err = code;
      ph  = slu_pkg::PH_ERROR;
    end
  endfunction

  function automatic int hex_digit(logic [20:0] c);
    if (c >= slu_pkg::CH_0 && c <= slu_pkg::CH_9) return int'(c - slu_pkg::CH_0);
    if (c >= slu_pkg::CH_UP_A && c <= slu_pkg::CH_UP_F) return int'(c - slu_pkg::CH_UP_A) + 10;
    if (c >= slu_pkg::CH_LO_A && c <= slu_pkg::CH_LO_F) return int'(c - slu_pkg::CH_LO_A) + 10;
    return -1;
  endfunction

  function automatic logic [31:0] simple_escape(logic [20:0] c);
    case (c)
      slu_pkg::CH_LO_A: return CC_BEL;
      slu_pkg::CH_LO_B: return CC_BS;
      slu_pkg::CH_LO_F: return CC_FF;
      slu_pkg::CH_LO_N: return CC_LF;
      slu_pkg::CH_LO_R: return CC_CR;
      slu_pkg::CH_LO_T: return CC_HT;
      slu_pkg::CH_LO_V: return CC_VT;
      default:          return 32'(c);
    endcase
  endfunction

  function automatic void body_text(logic [20:0] c);
    if (c == slu_pkg::CH_BSLASH) ph = slu_pkg::PH_ESC_START;
    else if (c == slu_pkg::CH_CR || c == slu_pkg::CH_LF) flag_error(slu_pkg::ST_INVALID);
    else if (c == slu_pkg::CH_QUOTE) ph = slu_pkg::PH_CLOSED;
    else push_res(slu_pkg::KIND_CHAR, 32'(c));
  endfunction

  function automatic void open_body(logic [20:0] c);
    if (c == slu_pkg::CH_AT) ph = slu_pkg::PH_AT_SEEN;
    else if (c == slu_pkg::CH_QUOTE) ph = slu_pkg::PH_QUOTED;
    else flag_error(slu_pkg::ST_INVALID);
  endfunction

  function automatic void close_run(logic [20:0] c);
    push_res(slu_pkg::KIND_CHAR, acc);
    ph = slu_pkg::PH_QUOTED;
    body_text(c);
  endfunction

  function automatic void escape_begin(logic [20:0] c);
    acc = '0;
    if (c == slu_pkg::CH_LO_X || c == slu_pkg::CH_UP_X) ph = slu_pkg::PH_HEX_RUN;
    else if (c == slu_pkg::CH_LO_D || c == slu_pkg::CH_UP_D) ph = slu_pkg::PH_DEC_RUN;
    else if (c >= slu_pkg::CH_0 && c <= slu_pkg::CH_7) begin
      acc = 32'(c - slu_pkg::CH_0);
      ph  = slu_pkg::PH_OCT_RUN;
    end else if (c == slu_pkg::CH_LO_U) begin
      need = 4'd4;
      ph   = slu_pkg::PH_FIXED_HEX;
    end else if (c == slu_pkg::CH_UP_U) begin
      need = 4'd8;
      ph   = slu_pkg::PH_FIXED_HEX;
    end else begin
      push_res(slu_pkg::KIND_CHAR, simple_escape(c));
      ph = slu_pkg::PH_QUOTED;
    end
  endfunction

  // one accepted item in, its results appended to due_results
  function automatic void decode_step(logic [20:0] c, logic fin);
    int            h;
    slu_pkg::res_t r;
    made = 0;
    case (ph)
      slu_pkg::PH_START: begin
        if (c == slu_pkg::CH_LO_W) begin
          pfx = slu_pkg::PFX_W;
          ph  = slu_pkg::PH_AFTER_PREFIX;
        end else if (c == slu_pkg::CH_LO_U) begin
          pfx = slu_pkg::PFX_U;
          ph  = slu_pkg::PH_AFTER_PREFIX;
        end else open_body(c);
      end
      slu_pkg::PH_AFTER_PREFIX: open_body(c);
      slu_pkg::PH_AT_SEEN:
        ph = (c == slu_pkg::CH_QUOTE) ? slu_pkg::PH_VERB_BODY : slu_pkg::PH_SWALLOW;
      slu_pkg::PH_VERB_BODY: begin
        if (c == slu_pkg::CH_QUOTE) ph = slu_pkg::PH_CLOSED;
        else push_res(slu_pkg::KIND_CHAR, 32'(c));
      end
      slu_pkg::PH_QUOTED:    body_text(c);
      slu_pkg::PH_ESC_START: escape_begin(c);
      slu_pkg::PH_HEX_RUN: begin
        h = hex_digit(c);
        if (h >= 0) acc = acc * 32'd16 + 32'(h);
        else close_run(c);
      end
      slu_pkg::PH_DEC_RUN: begin
        if (c >= slu_pkg::CH_0 && c <= slu_pkg::CH_9) acc = acc * 32'd10 + 32'(c - slu_pkg::CH_0);
        else close_run(c);
      end
      slu_pkg::PH_OCT_RUN: begin
        if (c >= slu_pkg::CH_0 && c <= slu_pkg::CH_7) acc = acc * 32'd8 + 32'(c - slu_pkg::CH_0);
        else close_run(c);
      end
      slu_pkg::PH_FIXED_HEX: begin
        h = hex_digit(c);
        if (h < 0) flag_error(slu_pkg::ST_HEX_EXPECTED);
        else begin
          acc = acc * 32'd16 + 32'(h);
          if (need != 4'd0) need = need - 4'd1;
          if (need == 4'd0) begin
            push_res(slu_pkg::KIND_CHAR, acc);
            ph = slu_pkg::PH_QUOTED;
          end
        end
      end
      slu_pkg::PH_CLOSED:  flag_error(slu_pkg::ST_INVALID);
      slu_pkg::PH_SWALLOW: ;
      default:             ph = slu_pkg::PH_ERROR;
    endcase

    if (fin) begin
      case (ph) inside
        slu_pkg::PH_START, slu_pkg::PH_AFTER_PREFIX: flag_error(slu_pkg::ST_INVALID);
        slu_pkg::PH_ESC_START: push_res(slu_pkg::KIND_CHAR, '0);
        slu_pkg::PH_HEX_RUN, slu_pkg::PH_DEC_RUN, slu_pkg::PH_OCT_RUN:
          push_res(slu_pkg::KIND_CHAR, acc);
        slu_pkg::PH_FIXED_HEX: flag_error(slu_pkg::ST_HEX_EXPECTED);
        default: ;
      endcase
      push_res(slu_pkg::KIND_SUMMARY, '0);
      clear_decoder();
    end

    if (made > 0) begin
      r = due_results.pop_back();
      r.last = 1'b1;
      due_results.push_back(r);
    end
  endfunction

  function automatic void check_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", field, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // output side first: a result leaving at this edge belongs to an earlier item
  always @(posedge clk) begin
    if (rst) begin
      clear_decoder();
      due_results.delete();
      fail_count     = 0;
      chars_seen     = 0;
      summaries_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d value %0h", kind, decoded_char);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("decoded_char", want.value, decoded_char);
          check_field("prefix_kind", 32'(want.prefix), 32'(prefix_kind));
          check_field("status", 32'(want.status), 32'(status));
          check_field("last_of_run", 32'(want.last), 32'(last_of_run));
          if (want.kind == slu_pkg::KIND_SUMMARY) summaries_seen++;
          else chars_seen++;
        end
      end
      if (in_valid && in_ready) decode_step(code_point, final_char);
    end
    pending <= due_results.size();
  end

endmodule

[tb/string_literal_unescaper_tb.sv]
`timescale 1ns / 1ps

// Feeds string-literal tokens into the unescaper one code point per item and
// leaves all checking to unescape_check, which predicts every result and
// compares it field by field as it leaves the block.
module string_literal_unescaper_tb;

  localparam int RANDOM_ITEMS = 145;

  typedef logic [slu_pkg::CP_W-1:0] cp_t;

  // code points not in the package
  localparam cp_t CP_MAX   = 21'h10FFFF;
  localparam cp_t CP_NUL   = 21'h0;
  localparam cp_t CP_SPACE = 21'h20;
  localparam cp_t CP_TILDE = 21'h7E;
  localparam cp_t CH_LO_G  = 21'h67;
  localparam cp_t CH_LO_Z  = 21'h7A;
  localparam cp_t CH_8     = 21'h38;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [20:0] code_point;
  logic        final_char;
  logic        out_valid;
  logic        out_ready;
  logic        kind;
  logic [31:0] decoded_char;
  logic [1:0]  prefix_kind;
  logic [1:0]  status;
  logic        last_of_run;

  int fail_count;
  int pending;
  int chars_seen;
  int summaries_seen;

  int items_sent;
  int tokens_sent;
  bit steady;            // both sides run without gaps while set
  cp_t tok[$];

  string_literal_unescaper i_dut (.*);
  unescape_check           i_check (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Character pickers
  // ---------------------------------------------------------------------
  function automatic cp_t hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return slu_pkg::CH_0 + cp_t'(r);
    if (r < 16) return slu_pkg::CH_LO_A + cp_t'(r - 10);
    return slu_pkg::CH_UP_A + cp_t'(r - 16);
  endfunction

  function automatic cp_t oct_char();
    return slu_pkg::CH_0 + cp_t'($urandom_range(0, 7));
  endfunction

  function automatic cp_t dec_char();
    return slu_pkg::CH_0 + cp_t'($urandom_range(0, 9));
  endfunction

  // Plain body text: anything but the characters that steer a quoted body.
  // Hex digits are weighted up so that runs sometimes swallow the next char.
  function automatic cp_t body_char();
    cp_t c;
    do begin
      case ($urandom_range(0, 3)) inside
        [0:1]:   c = cp_t'($urandom_range(CP_SPACE, CP_TILDE));
        2:       c = cp_t'($urandom_range(0, CP_MAX));
        default: c = hex_char();
      endcase
    end while (c == slu_pkg::CH_BSLASH || c == slu_pkg::CH_QUOTE
               || c == slu_pkg::CH_CR || c == slu_pkg::CH_LF);
    return c;
  endfunction

  function automatic cp_t noise_char();
    case ($urandom_range(0, 7))
      0:       return slu_pkg::CH_AT;
      1:       return slu_pkg::CH_QUOTE;
      2:       return slu_pkg::CH_BSLASH;
      3:       return slu_pkg::CH_LO_W;
      4:       return slu_pkg::CH_LO_U;
      5:       return slu_pkg::CH_CR;
      default: return cp_t'($urandom_range(0, CP_MAX));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Token building
  // ---------------------------------------------------------------------
  // One well-formed escape sequence, backslash included. Run lengths go past
  // 32 bits on purpose so the wrap of the escape value is exercised.
  task automatic push_escape();
    int n;
    tok.push_back(slu_pkg::CH_BSLASH);
    case ($urandom_range(0, 7)) inside
      0: begin
        tok.push_back($urandom_range(0, 1) ? slu_pkg::CH_LO_X : slu_pkg::CH_UP_X);
        n = $urandom_range(0, 10);
        repeat (n) tok.push_back(hex_char());
      end
      1: begin
        tok.push_back($urandom_range(0, 1) ? slu_pkg::CH_LO_D : slu_pkg::CH_UP_D);
        n = $urandom_range(0, 11);
        repeat (n) tok.push_back(dec_char());
      end
      2: begin
        tok.push_back(oct_char());
        n = $urandom_range(0, 11);
        repeat (n) tok.push_back(oct_char());
      end
      3: begin
        tok.push_back(slu_pkg::CH_LO_U);
        repeat (4) tok.push_back(hex_char());
      end
      4: begin
        tok.push_back(slu_pkg::CH_UP_U);
        repeat (8) tok.push_back(hex_char());
      end
      [5:6]: begin
        case ($urandom_range(0, 6))
          0:       tok.push_back(slu_pkg::CH_LO_A);
          1:       tok.push_back(slu_pkg::CH_LO_B);
          2:       tok.push_back(slu_pkg::CH_LO_F);
          3:       tok.push_back(slu_pkg::CH_LO_N);
          4:       tok.push_back(slu_pkg::CH_LO_R);
          5:       tok.push_back(slu_pkg::CH_LO_T);
          default: tok.push_back(slu_pkg::CH_LO_V);
        endcase
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       tok.push_back(slu_pkg::CH_BSLASH);
          1:       tok.push_back(slu_pkg::CH_QUOTE);
          default: tok.push_back(body_char());
        endcase
      end
    endcase
  endtask

  // Mostly well-formed quoted literals with random content; the rest is
  // verbatim bodies, broken literals and plain noise.
  task automatic build_token();
    int  form;
    int  n;
    bit  cut;
    tok.delete();
    form = $urandom_range(0, 19);
    if (form < 3) begin
      n = $urandom_range(1, 5);
      repeat (n) tok.push_back(noise_char());
    end else begin
      case ($urandom_range(0, 3))
        0:       tok.push_back(slu_pkg::CH_LO_W);
        1:       tok.push_back(slu_pkg::CH_LO_U);
        default: ;
      endcase
      if (form < 6) begin
        // verbatim body: backslashes are ordinary text here
        tok.push_back(slu_pkg::CH_AT);
        if ($urandom_range(0, 4) != 0) tok.push_back(slu_pkg::CH_QUOTE);
        n = $urandom_range(0, 5);
        repeat (n)
          tok.push_back(($urandom_range(0, 3) == 0) ? slu_pkg::CH_BSLASH : body_char());
        if ($urandom_range(0, 4) != 0) tok.push_back(slu_pkg::CH_QUOTE);
      end else begin
        tok.push_back(slu_pkg::CH_QUOTE);
        n   = $urandom_range(0, 6);
        cut = 1'b0;
        for (int i = 0; i < n && !cut; i++) begin
          case ($urandom_range(0, 11)) inside
            [0:4]: tok.push_back(body_char());
            11: begin
              // faults: line break, bad or short fixed-width escape, lone backslash
              case ($urandom_range(0, 3))
                0: tok.push_back($urandom_range(0, 1) ? slu_pkg::CH_CR : slu_pkg::CH_LF);
                1: begin
                  tok.push_back(slu_pkg::CH_BSLASH);
                  tok.push_back($urandom_range(0, 1) ? slu_pkg::CH_LO_U : slu_pkg::CH_UP_U);
                  repeat ($urandom_range(0, 3)) tok.push_back(hex_char());
                  tok.push_back($urandom_range(0, 1) ? CH_LO_G : slu_pkg::CH_QUOTE);
                end
                2: begin
                  tok.push_back(slu_pkg::CH_BSLASH);
                  tok.push_back($urandom_range(0, 1) ? slu_pkg::CH_LO_U : slu_pkg::CH_UP_U);
                  repeat ($urandom_range(0, 3)) tok.push_back(hex_char());
                  cut = 1'b1;
                end
                default: begin
                  tok.push_back(slu_pkg::CH_BSLASH);
                  cut = 1'b1;
                end
              endcase
            end
            default: push_escape();
          endcase
        end
        if (!cut) begin
          case ($urandom_range(0, 9)) inside
            [0:1]: ;                                   // left open
            2: begin
              tok.push_back(slu_pkg::CH_QUOTE);
              tok.push_back(body_char());              // junk after the close
            end
            default: tok.push_back(slu_pkg::CH_QUOTE);
          endcase
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------
  // Valid is only lowered when a gap is drawn, so back-to-back items keep it
  // high without a same-step lower/raise.
  task automatic send_char(input cp_t cp, input logic fin);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    code_point <= cp;
    final_char <= fin;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_token();
    if ($urandom_range(0, 7) == 0) steady = !steady;
    foreach (tok[i]) send_char(tok[i], i == tok.size() - 1);
    tokens_sent++;
  endtask

  // Hold the sender until the checker has nothing outstanding. The count is
  // registered and lags acceptance, so the loop waits before it first reads it.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver: its own random stall before every result, none while steady is set.
  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int rand_base;
    bit paused;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    code_point <= '0;
    final_char <= 1'b0;
    steady      = 1'b0;
    paused      = 1'b0;
    items_sent  = 0;
    tokens_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed tokens, one per special case.
    tok = {slu_pkg::CH_LO_W};                                    // prefix and nothing else
    send_token();
    tok = {slu_pkg::CH_LO_U, slu_pkg::CH_LF};                    // no quote after prefix
    send_token();
    tok = {slu_pkg::CH_AT, CH_LO_Z, slu_pkg::CH_QUOTE};          // '@' without quote
    send_token();
    tok = {slu_pkg::CH_AT, slu_pkg::CH_QUOTE, CP_MAX, slu_pkg::CH_QUOTE}; // verbatim, top
    send_token();
    tok = {slu_pkg::CH_QUOTE, slu_pkg::CH_BSLASH, slu_pkg::CH_LO_U, CH_LO_G}; // non-hex in \u
    send_token();
    tok = {slu_pkg::CH_QUOTE, slu_pkg::CH_CR, slu_pkg::CH_QUOTE}; // CR in body, then ignored
    send_token();
    // token ends inside \U
    tok = {slu_pkg::CH_QUOTE, slu_pkg::CH_BSLASH, slu_pkg::CH_UP_U, slu_pkg::CH_UP_F};
    send_token();
    // octal run cut by '8', close, then text after the closing quote
    tok = {slu_pkg::CH_QUOTE, slu_pkg::CH_BSLASH, slu_pkg::CH_7, CH_8,
           slu_pkg::CH_QUOTE, slu_pkg::CH_LO_X};
    send_token();
    tok = {slu_pkg::CH_QUOTE, CP_NUL, slu_pkg::CH_BSLASH};       // NUL, ends after backslash
    send_token();
    tok = {slu_pkg::CH_QUOTE, slu_pkg::CH_BSLASH, slu_pkg::CH_LO_X}; // ends in empty hex run
    send_token();
    drain();

    // Random tokens, with one full pause partway through.
    rand_base = items_sent;
    while (items_sent - rand_base < RANDOM_ITEMS) begin
      if (!paused && items_sent - rand_base >= RANDOM_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      build_token();
      send_token();
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d tokens (%0d code points); checked %0d decoded chars, %0d summaries.",
             tokens_sent, items_sent, chars_seen, summaries_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
